@@ src/multilevel_priority_thread_scheduler_core_defines.svh @@
// Assertion macros for the multilevel priority thread scheduler.
// Included by modules that carry concurrent assertions; no other dependency.
`ifndef MULTILEVEL_PRIORITY_THREAD_SCHEDULER_CORE_DEFINES_SVH
`define MULTILEVEL_PRIORITY_THREAD_SCHEDULER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MPTS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MPTS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MPTS_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define MPTS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ src/mpts_pkg.sv @@
// Shared types and constants for the multilevel priority thread scheduler.
// No dependencies.
`default_nettype none
package mpts_pkg;
    // Sizes fixed by the request and result field widths
    localparam int LEVELS_PER_CLASS = 32;
    localparam int CLASS_COUNT      = 4;
    localparam int THREAD_COUNT     = 64;

    localparam int REQ_YIELD = 0;
    localparam int REQ_READY = 1;
    localparam logic [2:0] ST_SWITCH   = 3'd0;
    localparam logic [2:0] ST_KEEP     = 3'd1;
    localparam logic [2:0] ST_IDLE     = 3'd2;
    localparam logic [2:0] ST_ENQUEUED = 3'd3;
    localparam logic [2:0] ST_REJECTED = 3'd4;
    localparam logic [1:0] TS_READY = 2'd0;

    // APB register map
    localparam logic [1:0] ADDR_RT_CLASS = 2'd0;

    typedef struct packed {
        logic       req_type;
        logic [5:0] thread_id;
        logic [1:0] thread_state;
        logic [1:0] sched_class;
        logic [4:0] nice_value;
    } sched_req_t;

    typedef struct packed {
        logic [5:0] next_thread;
        logic [2:0] status;
        logic [6:0] new_priority;
    } sched_rsp_t;
endpackage
`default_nettype wire

@@ src/mpts_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ src/multilevel_priority_thread_scheduler_core.sv @@
// Multilevel priority thread scheduler, top level.
// Depends on mpts_pkg, mpts_ram and the assertion macro header.
//
// One FIFO run queue per priority level (CLASS_COUNT*LEVELS_PER_CLASS levels,
// level 0 served first). Each level's head and tail share one word of a queue
// RAM; each thread's stored priority and next link share one word of a thread
// RAM. Both RAMs have a registered read. Non-empty bits and queued
// bits are flip-flops cleared at reset; one flag per thread marks a written
// priority so that a thread never yielded reads priority 0. Requests are
// handled one at a time. A ready request into a non-empty level also reads
// and rewrites the old tail's thread word. A yield requeues the thread when
// it is ready and not queued, then searches for the lowest non-empty level
// one group of 8 levels at a time; a yield that finds nothing ready answers
// idle after all 16 groups are searched. The result sits in an output
// register; the next request can be taken in the cycle after the result is
// handed over.
`default_nettype none
`include "multilevel_priority_thread_scheduler_core_defines.svh"
module multilevel_priority_thread_scheduler_core (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire mpts_pkg::sched_req_t   s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output mpts_pkg::sched_rsp_t        m_data,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [1:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mpts_pkg::*;

    localparam int NQ   = LEVELS_PER_CLASS * CLASS_COUNT;
    localparam int QW   = $clog2(NQ);
    localparam int TW   = $clog2(THREAD_COUNT);
    localparam int PW   = 7;
    localparam int HALF = LEVELS_PER_CLASS / 2;
    localparam int TOP  = NQ - 1;
    localparam int GRP  = 8;
    localparam int NG   = (NQ + GRP - 1) / GRP;
    localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
    localparam int QEW  = 2 * TW;   // queue word: head, tail
    localparam int TEW  = PW + TW;  // thread word: priority, link

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PRIO  = 4'd1; // thread word valid, decide
    localparam logic [3:0] S_APP   = 4'd2; // read queue word of target level
    localparam logic [3:0] S_APPR  = 4'd3; // write head/tail, read old tail
    localparam logic [3:0] S_APPL  = 4'd4; // link old tail to new thread
    localparam logic [3:0] S_SCAN  = 4'd5; // search lowest non-empty
    localparam logic [3:0] S_POPR  = 4'd6; // read queue word
    localparam logic [3:0] S_POPH  = 4'd7; // read link of head
    localparam logic [3:0] S_POPL  = 4'd8; // update head
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]    state_reg, state_next;
    sched_req_t    req_reg;
    logic [QW-1:0] q_reg;
    logic [GW-1:0] grp_reg;
    logic [TW-1:0] who_reg;
    logic [TW-1:0] last_reg;
    sched_rsp_t    rsp_reg;
    logic          m_valid_reg;
    logic [1:0]    rt_class_reg;

    logic [NQ-1:0]           nonempty_reg;
    logic [THREAD_COUNT-1:0] queued_reg;
    logic [THREAD_COUNT-1:0] prio_set_reg;

    // RAM ports; the queue RAM reads and writes at q_reg
    logic           qm_we, tm_we;
    logic [QEW-1:0] qm_wd, qm_rd;
    logic [TW-1:0]  tm_wa, tm_ra;
    logic [TEW-1:0] tm_wd, tm_rd;
    logic [TW-1:0]  q_head_rd, q_tail_rd, t_link_rd;
    logic [PW-1:0]  t_prio_rd;

    mpts_ram #(.WIDTH(QEW), .DEPTH(NQ)) u_queue (.aclk(aclk), .we(qm_we),
        .waddr(q_reg), .wdata(qm_wd), .raddr(q_reg), .rdata(qm_rd));
    mpts_ram #(.WIDTH(TEW), .DEPTH(THREAD_COUNT)) u_thread (.aclk(aclk),
        .we(tm_we), .waddr(tm_wa), .wdata(tm_wd), .raddr(tm_ra),
        .rdata(tm_rd));

    assign {q_head_rd, q_tail_rd} = qm_rd;
    assign {t_prio_rd, t_link_rd} = tm_rd;

    // Request decode, done once the thread word has been read
    logic          in_fire;
    logic          is_yield;
    logic          tid_ok;
    logic          recalc;
    logic          append_ok;
    logic [TW-1:0] req_tid;
    logic [PW-1:0] stored_sat;
    logic [8:0]    calc;
    logic [PW-1:0] recomputed;
    logic [PW-1:0] prio_new;

    assign in_fire  = s_valid && s_ready;
    assign req_tid  = req_reg.thread_id[TW-1:0];
    assign is_yield = (req_reg.req_type == 1'(REQ_YIELD));
    assign tid_ok   = 32'(req_reg.thread_id) < THREAD_COUNT;
    assign recalc   = is_yield && (req_reg.sched_class != rt_class_reg);

    always_comb begin
        // never-yielded thread reads as level 0
        stored_sat = '0;
        if (tid_ok && prio_set_reg[req_tid]) begin
            stored_sat = (32'(t_prio_rd) > TOP) ? PW'(TOP) : t_prio_rd;
        end
        calc = 9'(LEVELS_PER_CLASS) * 9'(req_reg.sched_class) + 9'(HALF)
             + 9'((stored_sat + 7'd1) & 7'(HALF - 1)) + 9'(req_reg.nice_value);
        recomputed = (32'(calc) > TOP) ? PW'(TOP) : calc[PW-1:0];
        prio_new   = recalc ? recomputed : stored_sat;
        // ready: not yet queued; yield: also must be in ready state
        append_ok  = tid_ok && !queued_reg[req_tid]
                   && (!is_yield || req_reg.thread_state == TS_READY);
    end

    // Lowest non-empty search over one group of levels per cycle
    logic [GRP-1:0] grp_bits;
    logic           grp_hit;
    logic [2:0]     grp_off;
    always_comb begin
        grp_bits = '0;
        for (int i = 0; i < GRP; i++) begin
            if (32'(grp_reg) * GRP + i < NQ) begin
                grp_bits[i] = nonempty_reg[QW'(32'(grp_reg) * GRP + i)];
            end
        end
        grp_hit = |grp_bits;
        grp_off = '0;
        for (int i = GRP - 1; i >= 0; i--) begin
            if (grp_bits[i]) begin
                grp_off = 3'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        qm_we = 1'b0;
        qm_wd = {q_head_rd, req_tid};
        tm_we = 1'b0;
        tm_wa = req_tid;
        tm_wd = {prio_new, t_link_rd};
        tm_ra = req_tid;
        unique case (state_reg)
            S_IDLE: begin
                tm_ra = s_data.thread_id[TW-1:0];
                if (in_fire) begin
                    state_next = S_PRIO;
                end
            end
            S_PRIO: begin
                // store recomputed level, keep the thread's link
                tm_we = recalc && tid_ok;
                if (append_ok) begin
                    state_next = S_APP;
                end else if (is_yield) begin
                    state_next = S_SCAN;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_APP: begin
                state_next = S_APPR;
            end
            S_APPR: begin
                qm_we = 1'b1;
                tm_ra = q_tail_rd;
                if (nonempty_reg[q_reg]) begin
                    state_next = S_APPL;
                end else begin
                    qm_wd = {req_tid, req_tid};
                    state_next = is_yield ? S_SCAN : S_OUT;
                end
            end
            S_APPL: begin
                // old tail keeps its priority, gets the new link
                tm_we = 1'b1;
                tm_wa = last_reg;
                tm_wd = {t_prio_rd, req_tid};
                state_next = is_yield ? S_SCAN : S_OUT;
            end
            S_SCAN: begin
                if (grp_hit) begin
                    state_next = S_POPR;
                end else if (32'(grp_reg) == NG - 1) begin
                    state_next = S_OUT;
                end
            end
            S_POPR: begin
                state_next = S_POPH;
            end
            S_POPH: begin
                tm_ra = q_head_rd;
                state_next = S_POPL;
            end
            S_POPL: begin
                if (who_reg != q_tail_rd) begin
                    qm_we = 1'b1;
                    qm_wd = {t_link_rd, q_tail_rd};
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            rt_class_reg <= '0;
            nonempty_reg <= '0;
            queued_reg   <= '0;
            prio_set_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (psel && penable && pwrite && paddr == ADDR_RT_CLASS) begin
                rt_class_reg <= pwdata[1:0];
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        req_reg <= s_data;
                    end
                end
                S_PRIO: begin
                    q_reg                <= QW'(prio_new);
                    grp_reg              <= '0;
                    rsp_reg.next_thread  <= '0;
                    rsp_reg.new_priority <= prio_new;
                    if (is_yield) begin
                        rsp_reg.status <= ST_IDLE;
                        if (recalc && tid_ok) begin
                            prio_set_reg[req_tid] <= 1'b1;
                        end
                    end else begin
                        rsp_reg.status <= append_ok ? ST_ENQUEUED : ST_REJECTED;
                    end
                end
                S_APPR: begin
                    last_reg            <= q_tail_rd;
                    nonempty_reg[q_reg] <= 1'b1;
                    queued_reg[req_tid] <= 1'b1;
                end
                S_SCAN: begin
                    if (grp_hit) begin
                        q_reg <= QW'(32'(grp_reg) * GRP + 32'(grp_off));
                    end else begin
                        grp_reg <= grp_reg + 1'b1;
                    end
                end
                S_POPH: begin
                    who_reg <= q_head_rd;
                end
                S_POPL: begin
                    if (who_reg == q_tail_rd) begin
                        nonempty_reg[q_reg] <= 1'b0;
                    end
                    queued_reg[who_reg] <= 1'b0;
                    rsp_reg.next_thread <= 6'(who_reg);
                    rsp_reg.status <= (6'(who_reg) == req_reg.thread_id)
                                    ? ST_KEEP : ST_SWITCH;
                end
                default: ;
            endcase
            if (state_reg != S_OUT && state_next == S_OUT) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;
    assign pready  = 1'b1;
    assign prdata  = {30'd0, rt_class_reg};

    logic pop_rd, app_wr;
    assign pop_rd = (state_reg == S_POPR);
    assign app_wr = (state_reg == S_APPR);

    // A request is never taken while a result is still pending.
    `MPTS_ASSERT_IMPL(a_no_overlap, aclk, aresetn, !(s_ready && m_valid), "accept while busy")
    // A pop in progress always targets a non-empty level.
    `MPTS_ASSERT_IMPL(a_pop_nonempty, aclk, aresetn, !pop_rd || nonempty_reg[q_reg], "empty pop")
    // After an append the thread is marked queued.
    `MPTS_ASSERT_NEXT(a_app_marks, aclk, aresetn, app_wr, queued_reg[req_tid], "append not marked")
endmodule
`default_nettype wire

@@ sim/tb_multilevel_priority_thread_scheduler_core.sv @@
// Testbench for multilevel_priority_thread_scheduler_core: directed and random
// scheduling requests checked against a behavioral queue predictor.
// Depends on mpts_pkg and the scheduler RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_multilevel_priority_thread_scheduler_core;
    import mpts_pkg::*;

    localparam int LEVELS    = 32;
    localparam int CLASSES   = 4;
    localparam int THREADS   = 64;
    localparam int NQ        = LEVELS * CLASSES;
    localparam int TOP       = NQ - 1;
    localparam int HALF      = LEVELS / 2;
    localparam int IDLE_LIMIT = 5000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    sched_req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sched_rsp_t m_data;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    multilevel_priority_thread_scheduler_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Predictor state: run queues as SV queues of thread ids
    logic [1:0] rt_class;
    int         run_q [NQ][$];
    logic [6:0] prio_of [THREADS];
    bit         queued [THREADS];

    sched_rsp_t expected_rsp [$];
    int errors = 0;
    int n_rsp = 0;
    int idle_cycles = 0;
    int n_idle = 0, n_keep = 0, n_reject = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (response %0d)", what, got, want, n_rsp);
        errors++;
    endtask

    function automatic int clamp_level(int p);
        return (p > TOP) ? TOP : p;
    endfunction

    function automatic sched_rsp_t predict_schedule(sched_req_t r);
        sched_rsp_t o;
        int p, tid, q;
        o = '0;
        tid = int'(r.thread_id);
        p = clamp_level(int'(prio_of[tid]));
        if (r.req_type == REQ_READY) begin
            if (queued[tid]) begin
                o.status = ST_REJECTED;
            end else begin
                run_q[p].push_back(tid);
                queued[tid] = 1'b1;
                o.status = ST_ENQUEUED;
            end
        end else begin
            if (r.sched_class != rt_class) begin
                p = ((p + 1) & (HALF - 1)) + LEVELS * r.sched_class + HALF + r.nice_value;
                p = clamp_level(p);
                prio_of[tid] = 7'(p);
            end
            if (r.thread_state == TS_READY && !queued[tid]) begin
                run_q[p].push_back(tid);
                queued[tid] = 1'b1;
            end
            o.status = ST_IDLE;
            for (q = 0; q < NQ; q++) begin
                if (run_q[q].size() != 0) begin
                    o.next_thread = 6'(run_q[q].pop_front());
                    queued[o.next_thread] = 1'b0;
                    o.status = (o.next_thread == r.thread_id) ? ST_KEEP : ST_SWITCH;
                    break;
                end
            end
        end
        o.new_priority = 7'(p);
        return o;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Stall mode: 0 random, 1 always ready
    bit steady_sink = 1'b0;

    // valid drops only when a gap follows, so back-to-back requests keep it high
    task automatic send_request(input sched_req_t r);
        int g;
        g = steady_sink ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_rsp.push_back(predict_schedule(r));
    endtask

    // Result side: random stalls, compare against oldest expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_rsp++;
                if (expected_rsp.size() == 0) begin
                    report_mismatch("unexpected response status", m_data.status, -1);
                end else begin
                    sched_rsp_t e;
                    e = expected_rsp.pop_front();
                    if (m_data.status != e.status)
                        report_mismatch("status", m_data.status, e.status);
                    if (m_data.next_thread != e.next_thread)
                        report_mismatch("next_thread", m_data.next_thread, e.next_thread);
                    if (m_data.new_priority != e.new_priority)
                        report_mismatch("new_priority", m_data.new_priority, e.new_priority);
                    if (e.status == ST_IDLE) n_idle++;
                    if (e.status == ST_KEEP) n_keep++;
                    if (e.status == ST_REJECTED) n_reject++;
                end
            end
            m_ready <= steady_sink ? 1'b1 : ($urandom_range(0, 9) < 7);
        end
    end

    // Watchdog: cycles with no request or response taken
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge aclk);
        // idle margin after the last response before the next test
        repeat (40) @(posedge aclk);
    endtask

    // APB write: setup then access, taken when psel/penable/pwrite/pready high
    task automatic write_rt_class(input logic [1:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_RT_CLASS; pwdata <= {30'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        rt_class = v;
    endtask

    function automatic sched_req_t make_req(int rt, int tid, int ts, int cls, int nice);
        sched_req_t r;
        r.req_type = 1'(rt); r.thread_id = 6'(tid); r.thread_state = 2'(ts);
        r.sched_class = 2'(cls); r.nice_value = 5'(nice);
        return r;
    endfunction

    // Extremes, every status, duplicate ready, yield while queued, idle pop
    task automatic test_directed();
        send_request(make_req(REQ_YIELD, 0, TS_READY, 0, 0));   // rt class: keep self
        send_request(make_req(REQ_YIELD, 5, 1, 1, 0));          // waiting, nothing ready
        send_request(make_req(REQ_READY, 63, 0, 0, 0));
        send_request(make_req(REQ_READY, 63, 0, 0, 0));         // duplicate
        send_request(make_req(REQ_READY, 0, 3, 3, 31));
        send_request(make_req(REQ_YIELD, 63, TS_READY, 3, 31)); // clamps to top
        send_request(make_req(REQ_YIELD, 63, 2, 2, 17));
        send_request(make_req(REQ_READY, 10, 0, 0, 0));
        send_request(make_req(REQ_READY, 11, 0, 0, 0));
        send_request(make_req(REQ_YIELD, 11, TS_READY, 1, 5));  // already queued
        send_request(make_req(REQ_YIELD, 20, 3, 2, 0));
        send_request(make_req(REQ_YIELD, 21, TS_READY, 1, 31));
        send_request(make_req(REQ_YIELD, 21, TS_READY, 1, 0));
        send_request(make_req(REQ_YIELD, 42, TS_READY, 2, 8));
        drain();
    endtask

    task automatic test_random(input int count);
        sched_req_t r;
        int i;
        for (i = 0; i < count; i++) begin
            r = sched_req_t'($urandom);
            // keep the pool small so queues grow and collide
            if ($urandom_range(0, 3) != 0) r.thread_id = 6'($urandom_range(0, 11));
            if ($urandom_range(0, 2) == 0) r.thread_state = TS_READY;
            if ($urandom_range(0, 2) != 0) r.req_type = 1'(REQ_READY);
            send_request(r);
            if (i == count / 2) drain();   // sender holds until all results are in
        end
        drain();
    endtask

    initial begin
        int q;
        rt_class = 0;
        for (q = 0; q < THREADS; q++) begin
            prio_of[q] = '0;
            queued[q] = 1'b0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        write_rt_class(2'd3);
        test_random(250);
        write_rt_class(2'd1);
        steady_sink = 1'b1;
        test_random(100);
        steady_sink = 1'b0;
        write_rt_class(2'd2);
        test_random(250);
        write_rt_class(2'd0);
        test_random(150);
        $display("covered %0d responses over four real-time class settings", n_rsp);
        $display("idle pops %0d, keep-current %0d, rejected readies %0d",
                 n_idle, n_keep, n_reject);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
